>>> sv/rrq_pkg.sv
// Shared widths, command and status codes, and structs of the ready queue.
package rrq_pkg;

  localparam int CMD_W     = 2;
  localparam int TASK_ID_W = 6;
  localparam int SLICE_W   = 4;
  localparam int TICK_W    = 5;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  // Number of distinct task numbers that the task_id field can carry.
  localparam int TASK_IDS = 64;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PICK    = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_QUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE  = 2'd2;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 4'd4;
  localparam logic [TICK_W-1:0]  TICK_MAX    = 5'd31;

  // Broadcast control for every cell of the queue.
  typedef struct packed {
    logic                 remove;
    logic                 rotate;
    logic                 enqueue;
    logic [TASK_ID_W-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 next_valid;
    logic [TASK_ID_W-1:0] next_task;
    logic                 resched;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   queued_count;
  } result_t;

endpackage

>>> sv/rrq_if.sv
// Handshake interfaces for the command, result and configuration channels.
interface rrq_req_if;
  logic                           valid;
  logic                           ready;
  logic [rrq_pkg::CMD_W-1:0]      cmd;
  logic [rrq_pkg::TASK_ID_W-1:0]  task_id;
  logic [rrq_pkg::TASK_ID_W-1:0]  current_task;
  modport source (output valid, cmd, task_id, current_task, input ready);
  modport sink (input valid, cmd, task_id, current_task, output ready);
endinterface

interface rrq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           next_valid;
  logic [rrq_pkg::TASK_ID_W-1:0]  next_task;
  logic                           resched;
  logic [rrq_pkg::STATUS_W-1:0]   status;
  logic [rrq_pkg::COUNT_W-1:0]    queued_count;
  modport source (output valid, next_valid, next_task, resched, status, queued_count,
                  input ready);
  modport sink (input valid, next_valid, next_task, resched, status, queued_count,
                output ready);
endinterface

interface rrq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rrq_pkg::SLICE_W-1:0]    slice_limit;
  modport source (output valid, slice_limit, input ready);
  modport sink (input valid, slice_limit, output ready);
endinterface

>>> sv/rrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/rrq_cell.sv
// One queue cell: holds one task number and shifts toward the head on removal.
module rrq_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  rrq_pkg::cell_ctrl_t           ctrl,
  input  logic                          left_valid,
  input  logic                          hit_in,
  input  logic                          right_valid,
  input  logic [rrq_pkg::TASK_ID_W-1:0] right_id,
  output logic                          valid,
  output logic [rrq_pkg::TASK_ID_W-1:0] id,
  output logic                          hit_out,
  output logic                          valid_next,
  output logic [rrq_pkg::TASK_ID_W-1:0] id_next
);

  logic match;

  assign match   = valid && (id == ctrl.key);
  assign hit_out = hit_in || match;

  always_comb begin
    valid_next = valid;
    id_next    = id;
    if (ctrl.rotate && valid && !right_valid) begin
      // The tail cell takes the rotated task after the gap has closed.
      valid_next = 1'b1;
      id_next    = ctrl.key;
    end else if (ctrl.remove && hit_out) begin
      valid_next = right_valid;
      id_next    = right_id;
    end else if (ctrl.enqueue && !valid && left_valid) begin
      valid_next = 1'b1;
      id_next    = ctrl.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    id <= id_next;
  end

endmodule

>>> sv/round_robin_ready_queue.sv
// Top level of the round-robin ready queue with time-slice rotation.
//
// Usage: commands arrive on req (cmd, task_id, current_task) and each one
// produces exactly one result transfer on rsp (next_valid, next_task, resched,
// status, queued_count). The cfg channel writes slice_limit at any time the
// block is idle; it is always ready.
// Timing: enqueue, dequeue and pick are applied in the cycle of the transfer
// and their result is registered into the result buffer. A tick for a task
// in range reads the slice counter memory in the transfer cycle and writes
// it back in the next, so req is held off during the write-back. The queue
// is a row of cells that close a gap or take a new tail. Throughput: one
// command per cycle while the result buffer has room and no tick writes back.
// A two-entry result buffer lets the block take new commands while results
// wait; when both entries are full req.ready drops until rsp takes one.
// Reset empties the queue, clears all slice counters (through per-task
// valid bits, no clearing pass) and sets slice_limit to four.
module round_robin_ready_queue #(
  parameter int MAX_TASKS = 64
) (
  input logic       clk,
  input logic       rst,
  rrq_req_if.sink   req,
  rrq_rsp_if.source rsp,
  rrq_cfg_if.sink   cfg
);

  // Only task numbers below this bound can ever be queued, so the queue
  // never needs more cells than that.
  localparam int CELLS = (MAX_TASKS < rrq_pkg::TASK_IDS) ? MAX_TASKS : rrq_pkg::TASK_IDS;
  localparam logic [rrq_pkg::TASK_ID_W:0] ID_LIMIT = (rrq_pkg::TASK_ID_W + 1)'(CELLS);
  localparam logic [rrq_pkg::COUNT_W-1:0] FULL_COUNT = rrq_pkg::COUNT_W'(CELLS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_TICK = 1'b1;

  logic                          state;
  logic [rrq_pkg::SLICE_W-1:0]   slice_limit;
  logic [rrq_pkg::COUNT_W-1:0]   count;
  logic [rrq_pkg::COUNT_W-1:0]   count_next;
  logic [rrq_pkg::TASK_ID_W-1:0] cur_q;
  logic [rrq_pkg::TASK_IDS-1:0]  tick_seen;

  logic [rrq_pkg::TICK_W-1:0]    ram_rdata;
  logic [rrq_pkg::TICK_W-1:0]    tick_old;
  logic [rrq_pkg::TICK_W-1:0]    tick_inc;
  logic [rrq_pkg::TICK_W-1:0]    tick_wdata;
  logic                          expire;

  logic                          req_fire;
  logic                          in_tick;
  logic                          tick_go;
  logic                          id_ok;
  logic                          cur_ok;
  logic                          present;
  logic                          enq_do;
  logic                          deq_do;
  logic                          rot_do;
  rrq_pkg::cell_ctrl_t           ctrl;

  logic [CELLS-1:0]              cell_valid;
  logic [CELLS-1:0]              cell_valid_next;
  logic [rrq_pkg::TASK_ID_W-1:0] cell_id [CELLS];
  logic [rrq_pkg::TASK_ID_W-1:0] cell_id_next [CELLS];
  logic [CELLS:0]                hit;

  rrq_pkg::result_t              res;
  logic                          push;
  logic                          pop;
  rrq_pkg::result_t              fifo_q [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    fill;

  // Handshakes. Configuration writes are always taken.
  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE) && (fill != 2'd2);
  assign req_fire  = req.valid && req.ready;
  assign in_tick   = (state == S_TICK);

  assign id_ok   = {1'b0, req.task_id} < ID_LIMIT;
  assign cur_ok  = {1'b0, req.current_task} < ID_LIMIT;
  assign tick_go = req_fire && (req.cmd == rrq_pkg::CMD_TICK) && cur_ok;

  // Slice counter update for the tick in flight. A counter never written
  // since reset reads as zero.
  assign tick_old   = tick_seen[cur_q] ? ram_rdata : '0;
  assign tick_inc   = (tick_old < rrq_pkg::TICK_MAX) ? tick_old + 1'b1 : tick_old;
  assign expire     = rrq_pkg::TICK_W'(slice_limit) < tick_inc;
  assign tick_wdata = expire ? '0 : tick_inc;

  rrq_ram #(
    .WIDTH (rrq_pkg::TICK_W),
    .DEPTH (rrq_pkg::TASK_IDS)
  ) u_slice_ram (
    .clk   (clk),
    .we    (in_tick),
    .waddr (cur_q),
    .wdata (tick_wdata),
    .raddr (req.current_task),
    .rdata (ram_rdata)
  );

  // The cells search for the key; the hit chain out of the last cell tells
  // whether the key is queued at all.
  assign present = hit[CELLS];
  assign enq_do  = req_fire && (req.cmd == rrq_pkg::CMD_ENQUEUE) && id_ok && !present &&
                   (count != FULL_COUNT);
  assign deq_do  = req_fire && (req.cmd == rrq_pkg::CMD_DEQUEUE) && present;
  assign rot_do  = in_tick && expire && present;

  assign ctrl.enqueue = enq_do;
  assign ctrl.remove  = deq_do || rot_do;
  assign ctrl.rotate  = rot_do;
  assign ctrl.key     = in_tick ? cur_q : req.task_id;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic                          left_valid;
    logic                          right_valid;
    logic [rrq_pkg::TASK_ID_W-1:0] right_id;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_valid = cell_valid[i-1];
    end

    if (i == CELLS - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_id    = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[i+1];
      assign right_id    = cell_id[i+1];
    end

    rrq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_valid  (left_valid),
      .hit_in      (hit[i]),
      .right_valid (right_valid),
      .right_id    (right_id),
      .valid       (cell_valid[i]),
      .id          (cell_id[i]),
      .hit_out     (hit[i+1]),
      .valid_next  (cell_valid_next[i]),
      .id_next     (cell_id_next[i])
    );
  end

  assign count_next = count + rrq_pkg::COUNT_W'(enq_do) - rrq_pkg::COUNT_W'(deq_do);

  // Result of the step, taken from the queue state after the step.
  always_comb begin
    res.next_valid   = cell_valid_next[0];
    res.next_task    = cell_valid_next[0] ? cell_id_next[0] : '0;
    res.queued_count = count_next;
    res.resched      = 1'b0;
    res.status       = rrq_pkg::STATUS_OK;
    if (in_tick) begin
      res.resched = expire;
      res.status  = present ? rrq_pkg::STATUS_OK : rrq_pkg::STATUS_NOT_QUEUED;
    end else begin
      case (req.cmd)
        rrq_pkg::CMD_ENQUEUE: begin
          if (!id_ok) begin
            res.status = rrq_pkg::STATUS_NOT_QUEUED;
          end else if (present) begin
            res.status = rrq_pkg::STATUS_DUPLICATE;
          end
        end
        rrq_pkg::CMD_DEQUEUE: begin
          if (!present) begin
            res.status = rrq_pkg::STATUS_NOT_QUEUED;
          end
        end
        rrq_pkg::CMD_TICK: begin
          // Only a tick for an out-of-range task finishes here.
          res.status = rrq_pkg::STATUS_NOT_QUEUED;
        end
        rrq_pkg::CMD_PICK: begin
          if (count == '0) begin
            res.status = rrq_pkg::STATUS_NOT_QUEUED;
          end
        end
        default: begin
          res.status = rrq_pkg::STATUS_OK;
        end
      endcase
    end
  end

  assign push = in_tick || (req_fire && !tick_go);
  assign pop  = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slice_limit <= rrq_pkg::SLICE_RESET;
      count       <= '0;
      tick_seen   <= '0;
      wr_ptr      <= 1'b0;
      rd_ptr      <= 1'b0;
      fill        <= 2'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (tick_go) begin
            state <= S_TICK;
          end
        end
        S_TICK: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg.valid && cfg.ready) begin
        slice_limit <= cfg.slice_limit;
      end
      count <= count_next;
      if (in_tick) begin
        tick_seen[cur_q] <= 1'b1;
      end
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      cur_q <= req.current_task;
    end
    if (push) begin
      fifo_q[wr_ptr] <= res;
    end
  end

  assign rsp.valid        = (fill != 2'd0);
  assign rsp.next_valid   = fifo_q[rd_ptr].next_valid;
  assign rsp.next_task    = fifo_q[rd_ptr].next_task;
  assign rsp.resched      = fifo_q[rd_ptr].resched;
  assign rsp.status       = fifo_q[rd_ptr].status;
  assign rsp.queued_count = fifo_q[rd_ptr].queued_count;

  // The head cell holds a task exactly when the count is nonzero.
  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == !cell_valid[0])
    else $error("queue head and count disagree");

  // The result buffer never holds more than two results.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("result buffer overflow");

  // A tick in range enters the write-back state and then returns to idle.
  a_tick_enters: assert property (@(posedge clk) disable iff (rst)
    tick_go |=> (state == S_TICK))
    else $error("tick did not start its write-back");

  a_tick_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK) |=> (state == S_IDLE))
    else $error("tick write-back did not finish");

  // A rotation keeps the number of queued tasks.
  a_rotate_keeps_count: assert property (@(posedge clk) disable iff (rst)
    rot_do |=> (count == $past(count)))
    else $error("rotation changed the queue length");

endmodule

>>> tb/tb_round_robin_ready_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the round-robin ready queue: directed, pressure and random tests.
module tb_round_robin_ready_queue;

  localparam int MAX_TASKS   = 64;
  localparam int IDLE_PCT    = 13;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 170;

  logic clk = 1'b0;
  logic rst;

  rrq_req_if req_ch ();
  rrq_rsp_if rsp_ch ();
  rrq_cfg_if cfg_ch ();

  round_robin_ready_queue #(
    .MAX_TASKS (MAX_TASKS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // A 2 ns clock: one delay for the high half, one for the low half.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler state as the testbench sees it. The run order keeps the head at
  // entry zero; only entries below run_len are ever looked at.
  // ---------------------------------------------------------------------------
  logic [rrq_pkg::TASK_ID_W-1:0] run_order [MAX_TASKS];
  int unsigned                   run_len;
  bit                            is_queued [MAX_TASKS];
  logic [rrq_pkg::TICK_W-1:0]    ticks_used [MAX_TASKS];
  logic [rrq_pkg::SLICE_W-1:0]   model_limit;

  // Results predicted for accepted commands, oldest first.
  rrq_pkg::result_t expected_rsp[$];

  int mismatches    = 0;
  int results_seen  = 0;
  int cmd_count [4] = '{0, 0, 0, 0};
  int expiry_count  = 0;
  int peak_len      = 0;

  // Traffic shaping shared by the sender and the receiver. A test asks for a
  // long stall by bumping hold_requests; the receiver notes it in holds_started.
  bit quiet_mode    = 1'b0;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left     = 0;

  function automatic void reset_model();
    model_limit = rrq_pkg::SLICE_RESET;
    run_len     = 0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      run_order[i]  = '0;
      is_queued[i]  = 1'b0;
      ticks_used[i] = '0;
    end
  endfunction

  function automatic int unsigned position_of(logic [rrq_pkg::TASK_ID_W-1:0] id);
    for (int unsigned i = 0; i < run_len; i++) begin
      if (run_order[i] == id) return i;
    end
    return run_len;
  endfunction

  // Removes one entry and closes the gap behind it.
  function automatic void drop_at(int unsigned pos);
    for (int unsigned i = pos; i + 1 < run_len; i++) run_order[i] = run_order[i + 1];
    run_len--;
  endfunction

  // Applies one command to the scheduler state and returns the result that the
  // block must report for it.
  function automatic rrq_pkg::result_t schedule_step(logic [rrq_pkg::CMD_W-1:0] op,
                                                     logic [rrq_pkg::TASK_ID_W-1:0] id,
                                                     logic [rrq_pkg::TASK_ID_W-1:0] cur);
    rrq_pkg::result_t r;
    int unsigned      pos;
    r        = '0;
    r.status = rrq_pkg::STATUS_OK;
    case (op)
      rrq_pkg::CMD_ENQUEUE: begin
        if (is_queued[id]) begin
          r.status = rrq_pkg::STATUS_DUPLICATE;
        end else if (run_len < MAX_TASKS) begin
          run_order[run_len] = id;
          run_len++;
          is_queued[id] = 1'b1;
        end
      end
      rrq_pkg::CMD_DEQUEUE: begin
        if (!is_queued[id]) begin
          r.status = rrq_pkg::STATUS_NOT_QUEUED;
        end else begin
          pos = position_of(id);
          if (pos < run_len) drop_at(pos);
          is_queued[id] = 1'b0;
        end
      end
      rrq_pkg::CMD_TICK: begin
        // The slice counter runs even for a task that is not queued.
        if (ticks_used[cur] < rrq_pkg::TICK_MAX) ticks_used[cur]++;
        if (!is_queued[cur]) r.status = rrq_pkg::STATUS_NOT_QUEUED;
        if (ticks_used[cur] > model_limit) begin
          ticks_used[cur] = '0;
          r.resched       = 1'b1;
          expiry_count++;
          if (is_queued[cur]) begin
            pos = position_of(cur);
            if (pos < run_len) begin
              drop_at(pos);
              run_order[run_len] = cur;
              run_len++;
            end
          end
        end
      end
      rrq_pkg::CMD_PICK: begin
        if (run_len == 0) r.status = rrq_pkg::STATUS_NOT_QUEUED;
      end
      default: begin
        r.status = rrq_pkg::STATUS_OK;
      end
    endcase
    if (run_len > peak_len) peak_len = run_len;
    r.next_valid   = (run_len > 0);
    r.next_task    = (run_len > 0) ? run_order[0] : '0;
    r.queued_count = rrq_pkg::COUNT_W'(run_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Valid stays high from one command to the next unless an idle
  // cycle is drawn, so it is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(logic [rrq_pkg::CMD_W-1:0] op, logic [rrq_pkg::TASK_ID_W-1:0] id,
                          logic [rrq_pkg::TASK_ID_W-1:0] cur);
    while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= op;
    req_ch.task_id      <= id;
    req_ch.current_task <= cur;
    do @(posedge clk); while (!req_ch.ready);
    // The command was taken at this edge: predict its result now, in order.
    expected_rsp.push_back(schedule_step(op, id, cur));
    cmd_count[op]++;
  endtask

  // Stops offering commands and waits until every predicted result has come.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  // The slice limit is only changed while nothing is in flight.
  task automatic write_limit(logic [rrq_pkg::SLICE_W-1:0] value);
    wait_drained();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.slice_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    model_limit = value;
  endtask

  // A random command that mostly works on a narrow window of task numbers, so
  // that duplicates, hits on dequeue and expiring slices are common, with the
  // rest spread over the full task range.
  task automatic send_random_cmd(int unsigned base, int unsigned span);
    logic [rrq_pkg::CMD_W-1:0]     op;
    logic [rrq_pkg::TASK_ID_W-1:0] id;
    logic [rrq_pkg::TASK_ID_W-1:0] cur;
    int unsigned                   roll;
    roll = $urandom_range(99);
    if (roll < 35) op = rrq_pkg::CMD_ENQUEUE;
    else if (roll < 55) op = rrq_pkg::CMD_DEQUEUE;
    else if (roll < 90) op = rrq_pkg::CMD_TICK;
    else op = rrq_pkg::CMD_PICK;
    if ($urandom_range(99) < 75) id = rrq_pkg::TASK_ID_W'(base + $urandom_range(span - 1));
    else id = rrq_pkg::TASK_ID_W'($urandom);
    roll = $urandom_range(99);
    if (run_len > 0 && roll < 60) cur = run_order[0];
    else if (roll < 85) cur = rrq_pkg::TASK_ID_W'(base + $urandom_range(span - 1));
    else cur = rrq_pkg::TASK_ID_W'($urandom);
    send_cmd(op, id, cur);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side. A hold request from a test starts a long stall that this
  // process counts out on its own; otherwise ready drops at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (holds_started != hold_requests) begin
        holds_started = hold_requests;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (quiet_mode) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    rrq_pkg::result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result transfer with no command waiting for it", $time);
      end else begin
        want = expected_rsp.pop_front();
        check_field("next_valid", want.next_valid, rsp_ch.next_valid);
        check_field("next_task", want.next_task, rsp_ch.next_task);
        check_field("resched", want.resched, rsp_ch.resched);
        check_field("status", want.status, rsp_ch.status);
        check_field("queued_count", want.queued_count, rsp_ch.queued_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset limit of four: empty queue corner cases, duplicates, removal from
  // the middle and the head, and rotation after the fifth tick.
  task automatic test_directed();
    send_cmd(rrq_pkg::CMD_PICK, 6'd0, 6'd0);        // pick on an empty queue
    send_cmd(rrq_pkg::CMD_DEQUEUE, 6'd0, 6'd0);     // removal of a task that is not queued
    send_cmd(rrq_pkg::CMD_TICK, 6'd0, 6'd63);       // tick for an idle task still counts
    send_cmd(rrq_pkg::CMD_ENQUEUE, 6'd0, 6'd0);
    send_cmd(rrq_pkg::CMD_ENQUEUE, 6'd63, 6'd0);
    send_cmd(rrq_pkg::CMD_ENQUEUE, 6'd42, 6'd0);
    send_cmd(rrq_pkg::CMD_ENQUEUE, 6'd0, 6'd0);     // already queued
    send_cmd(rrq_pkg::CMD_PICK, 6'd0, 6'd0);
    // The fifth tick moves task 0 to the tail.
    repeat (5) send_cmd(rrq_pkg::CMD_TICK, 6'd0, 6'd0);
    send_cmd(rrq_pkg::CMD_DEQUEUE, 6'd42, 6'd0);    // gap in the middle
    send_cmd(rrq_pkg::CMD_DEQUEUE, 6'd42, 6'd0);    // now gone
    // Task 63 already holds one tick from before it was queued.
    repeat (4) send_cmd(rrq_pkg::CMD_TICK, 6'd63, 6'd63);
    send_cmd(rrq_pkg::CMD_DEQUEUE, 6'd0, 6'd63);    // head removal
    send_cmd(rrq_pkg::CMD_DEQUEUE, 6'd63, 6'd63);
    send_cmd(rrq_pkg::CMD_PICK, 6'd63, 6'd0);
  endtask

  // Both ends of the slice limit, including an expiring tick for a task that
  // is not queued.
  task automatic test_slice_limits();
    write_limit(4'd0);
    send_cmd(rrq_pkg::CMD_ENQUEUE, 6'd5, 6'd0);
    send_cmd(rrq_pkg::CMD_ENQUEUE, 6'd9, 6'd0);
    repeat (3) send_cmd(rrq_pkg::CMD_TICK, 6'd0, 6'd5);
    send_cmd(rrq_pkg::CMD_TICK, 6'd0, 6'd33);
    write_limit(4'd15);
    repeat (16) send_cmd(rrq_pkg::CMD_TICK, 6'd0, 6'd9);
    send_cmd(rrq_pkg::CMD_DEQUEUE, 6'd5, 6'd0);
    send_cmd(rrq_pkg::CMD_DEQUEUE, 6'd9, 6'd0);
    write_limit(rrq_pkg::SLICE_RESET);
  endtask

  // Fills the queue with every task number in random order, works on the full
  // queue, then empties it again in another order.
  task automatic test_full_queue();
    logic [rrq_pkg::TASK_ID_W-1:0] order [MAX_TASKS];
    logic [rrq_pkg::TASK_ID_W-1:0] swap;
    int unsigned                   j;
    for (int i = 0; i < MAX_TASKS; i++) order[i] = rrq_pkg::TASK_ID_W'(i);
    for (int i = MAX_TASKS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    foreach (order[i]) send_cmd(rrq_pkg::CMD_ENQUEUE, order[i], order[i]);
    send_cmd(rrq_pkg::CMD_ENQUEUE, order[$urandom_range(MAX_TASKS - 1)], 6'd0);
    send_cmd(rrq_pkg::CMD_PICK, 6'd0, 6'd0);
    repeat (8) send_cmd(rrq_pkg::CMD_TICK, 6'd0, run_order[0]);
    for (int i = MAX_TASKS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    foreach (order[i]) send_cmd(rrq_pkg::CMD_DEQUEUE, order[i], order[i]);
  endtask

  // The receiver stalls for a long stretch while commands keep coming, so the
  // result buffer fills and the block has to push back on its input.
  task automatic test_backpressure();
    hold_requests++;
    repeat (24) send_random_cmd($urandom_range(63), 6);
  endtask

  // The sender stops in the middle of a stream until every result is back.
  task automatic test_sender_pause();
    int unsigned base;
    base = $urandom_range(63);
    repeat (30) send_random_cmd(base, 8);
    wait_drained();
    repeat (30) send_random_cmd(base, 8);
  endtask

  // Random phases, each with its own slice limit and task window. One phase
  // runs with no idling on either side.
  task automatic test_random_phases();
    logic [rrq_pkg::SLICE_W-1:0] limits [5];
    limits = '{4'd15, 4'd0, rrq_pkg::SLICE_W'($urandom), 4'd1, rrq_pkg::SLICE_W'($urandom)};
    foreach (limits[p]) begin
      write_limit(limits[p]);
      quiet_mode = (p == 2);
      repeat (PHASE_ITEMS) send_random_cmd($urandom_range(63), $urandom_range(16, 4));
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.cmd          <= rrq_pkg::CMD_PICK;
    req_ch.task_id      <= '0;
    req_ch.current_task <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.slice_limit  <= rrq_pkg::SLICE_RESET;
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_slice_limits();
    test_full_queue();
    test_backpressure();
    test_sender_pause();
    test_random_phases();

    // Let the last results come home, then keep running with nothing in flight so
    // that a stray extra transfer would still be caught.
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Checked %0d results: %0d enqueues, %0d dequeues, %0d ticks, %0d picks.",
             results_seen, cmd_count[rrq_pkg::CMD_ENQUEUE], cmd_count[rrq_pkg::CMD_DEQUEUE],
             cmd_count[rrq_pkg::CMD_TICK], cmd_count[rrq_pkg::CMD_PICK]);
    $display("Slices expired %0d times, queue depth reached %0d, %0d mismatches.",
             expiry_count, peak_len, mismatches);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("[round_robin_ready_queue] OK");
    end else begin
      $display("[round_robin_ready_queue] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run ends far sooner.
  initial begin
    #400000;
    $display("Run did not complete in the allotted time.");
    $display("[round_robin_ready_queue] ERROR");
    $finish;
  end

endmodule
